### rtl/vbnp_pkg.sv
// Shared types and constants for the video bus name-table / palette map.
package vbnp_pkg;

  localparam int unsigned NumTablesDef = 4;
  localparam int unsigned TableBytes   = 1024;  // name bytes plus attribute bytes per table
  localparam int unsigned PalEntries   = 32;

  // Reset values of the quadrant table selectors.
  localparam logic [1:0] MirrorRst0 = 2'd0;
  localparam logic [1:0] MirrorRst1 = 2'd1;
  localparam logic [1:0] MirrorRst2 = 2'd0;
  localparam logic [1:0] MirrorRst3 = 2'd1;

  typedef enum logic [1:0] {
    CfgMirror0 = 2'd0,
    CfgMirror1 = 2'd1,
    CfgMirror2 = 2'd2,
    CfgMirror3 = 2'd3
  } cfg_reg_e;

  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // Decoded kind of one bus request.
  typedef struct packed {
    logic       cart;      // below 0x2000
    logic       vram;      // name or attribute byte
    logic       pal;       // palette byte
    logic       write;
    logic       bg_set;    // palette write with address bits 3:0 zero
    logic       pal_pair;  // palette write to entry 0 of a palette
    logic [4:0] pal_idx;
  } access_t;

endpackage

### rtl/vbnp_decode.sv
// Address decode: region, physical table and palette entry of a request.
module vbnp_decode import vbnp_pkg::*; #(
  parameter int unsigned NUM_TABLES = NumTablesDef,
  localparam int unsigned TblW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
  localparam int unsigned VramAw    = TblW + $clog2(TableBytes)
) (
  input  logic             command_i,
  input  logic [15:0]      address_i,
  input  logic [3:0][1:0]  mirror_sel_i,
  output access_t          acc_o,
  output logic [VramAw-1:0] vram_addr_o
);

  localparam logic [2:0] NumT = 3'(NUM_TABLES);

  logic [1:0] sel;
  logic [2:0] sel_ext;
  logic [2:0] tbl_full;
  logic       is_wr;

  assign is_wr   = (command_i == CmdWrite);
  assign sel     = mirror_sel_i[address_i[11:10]];
  assign sel_ext = {1'b0, sel};
  // Fold a selector beyond the table count back into range.
  assign tbl_full = (sel_ext >= NumT) ? sel_ext - NumT : sel_ext;

  always_comb begin
    acc_o.cart     = (address_i[15:13] == 3'b000);
    acc_o.vram     = (address_i[15:13] == 3'b001) && (address_i[13:8] != 6'h3F);
    acc_o.pal      = (address_i[15:8] == 8'h3F);
    acc_o.write    = is_wr;
    acc_o.bg_set   = acc_o.pal && is_wr && (address_i[3:0] == 4'h0);
    acc_o.pal_pair = acc_o.pal && is_wr && (address_i[1:0] == 2'b00);
    acc_o.pal_idx  = address_i[4:0];
  end

  assign vram_addr_o = {tbl_full[TblW-1:0], address_i[9:0]};

endmodule

### rtl/vbnp_vram.sv
// Single-port table memory holding name and attribute bytes of all tables.
module vbnp_vram import vbnp_pkg::*; #(
  parameter int unsigned NUM_TABLES = NumTablesDef,
  localparam int unsigned TblW      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1,
  localparam int unsigned VramAw    = TblW + $clog2(TableBytes),
  localparam int unsigned Depth     = NUM_TABLES * TableBytes
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [VramAw-1:0] addr_i,
  input  logic [7:0]        wdata_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/vbnp_palette.sv
// Palette entries and background colour, with registered read.
module vbnp_palette import vbnp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  access_t    acc_i,
  input  logic [7:0] wdata_i,
  output logic [7:0] rdata_o,
  output logic [7:0] backdrop_o
);

  logic [7:0] pal_q [PalEntries];
  logic [7:0] rdata_q;
  logic [7:0] backdrop_q;
  logic [4:0] idx_lo;
  logic [4:0] idx_hi;

  // Entry 0 of a palette lands in both halves of the palette space.
  assign idx_lo = {1'b0, acc_i.pal_idx[3:2], 2'b00};
  assign idx_hi = {1'b1, acc_i.pal_idx[3:2], 2'b00};

  always_ff @(posedge clk_i) begin
    if (en_i && acc_i.pal) begin
      if (acc_i.write) begin
        if (acc_i.pal_pair) begin
          pal_q[idx_lo] <= wdata_i;
          pal_q[idx_hi] <= wdata_i;
        end else begin
          pal_q[acc_i.pal_idx] <= wdata_i;
        end
      end else begin
        rdata_q <= pal_q[acc_i.pal_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backdrop_q <= 8'h00;
    end else if (en_i && acc_i.bg_set) begin
      backdrop_q <= wdata_i;
    end
  end

  assign rdata_o    = rdata_q;
  assign backdrop_o = backdrop_q;

endmodule

### rtl/video_bus_nametable_palette_map.sv
// Top level of the video bus name-table / palette map.
//
// Channel   | Direction | Handshake              | Payload
// s_axis    | in        | tvalid / tready        | tdata: address, write_data; tuser: command
// m_axis    | out       | tvalid / tready        | tdata: read_data, background_colour;
//           |           |                        | tuser: cartridge_access
// cfg       | in        | cfg_valid_i/cfg_ready_o| cfg_addr_i: selector index, cfg_data_i
//
// One request per cycle while the output is not stalled; the memory read is registered at the
// accepting edge, and the output register loads from it when the memory stage advances.
// Reset clears the pipeline valids, the table selectors and the background colour;
// table and palette bytes stay undefined until written, so no clearing pass runs.
// A stalled output holds the request waiting on memory data; a new request is taken
// only when that stage can move on.
module video_bus_nametable_palette_map import vbnp_pkg::*; #(
  parameter int unsigned NUM_TABLES = NumTablesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] address, [23:16] write_data
  input  logic [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] read_data, [15:8] background_colour
  output logic [0:0]  m_axis_tuser,   // [0] cartridge_access
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [1:0]  cfg_data_i
);

  localparam int unsigned TblW   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned VramAw = TblW + $clog2(TableBytes);

  logic [3:0][1:0]   mirror_q;
  access_t           acc;
  logic [VramAw-1:0] vram_addr;
  logic              accept;
  logic              s1_adv;
  logic [7:0]        vram_rdata;
  logic [7:0]        pal_rdata;
  logic [7:0]        backdrop;
  logic [7:0]        s1_rdata;

  logic              s1_valid_q;
  access_t           s1_acc_q;
  logic              out_valid_q;
  logic [7:0]        out_rdata_q;
  logic [7:0]        out_bg_q;
  logic              out_cart_q;

  // Configuration: selectors are always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q[0] <= MirrorRst0;
      mirror_q[1] <= MirrorRst1;
      mirror_q[2] <= MirrorRst2;
      mirror_q[3] <= MirrorRst3;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgMirror0: mirror_q[0] <= cfg_data_i;
        CfgMirror1: mirror_q[1] <= cfg_data_i;
        CfgMirror2: mirror_q[2] <= cfg_data_i;
        CfgMirror3: mirror_q[3] <= cfg_data_i;
        default:    mirror_q    <= mirror_q;
      endcase
    end
  end

  vbnp_decode #(.NUM_TABLES(NUM_TABLES)) u_decode (
    .command_i    (s_axis_tuser[0]),
    .address_i    (s_axis_tdata[15:0]),
    .mirror_sel_i (mirror_q),
    .acc_o        (acc),
    .vram_addr_o  (vram_addr)
  );

  // Advance the memory stage when the output register is free or drains.
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  vbnp_vram #(.NUM_TABLES(NUM_TABLES)) u_vram (
    .clk_i   (clk_i),
    .en_i    (accept && acc.vram),
    .we_i    (acc.write),
    .addr_i  (vram_addr),
    .wdata_i (s_axis_tdata[23:16]),
    .rdata_o (vram_rdata)
  );

  vbnp_palette u_palette (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (accept),
    .acc_i      (acc),
    .wdata_i    (s_axis_tdata[23:16]),
    .rdata_o    (pal_rdata),
    .backdrop_o (backdrop)
  );

  always_comb begin
    s1_rdata = 8'h00;
    if (!s1_acc_q.write) begin
      if (s1_acc_q.vram) begin
        s1_rdata = vram_rdata;
      end else if (s1_acc_q.pal) begin
        s1_rdata = pal_rdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers; the backdrop is read once this request has updated it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_acc_q <= acc;
    end
    if (s1_adv) begin
      out_rdata_q <= s1_rdata;
      out_bg_q    <= backdrop;
      out_cart_q  <= s1_acc_q.cart;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {out_bg_q, out_rdata_q};
  assign m_axis_tuser[0] = out_cart_q;

`ifndef SYNTHESIS
  a_cart_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("cartridge result carries nonzero read data");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted request missing from memory stage");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_acc_q))
    else $error("stalled memory stage lost its request");
`endif

endmodule

### dv/video_bus_nametable_palette_map_tb.sv
// Self-checking testbench for the video bus name-table / palette map.
module video_bus_nametable_palette_map_tb;
  import vbnp_pkg::*;

  localparam int unsigned NumTables     = NumTablesDef;
  localparam int unsigned NameBytes     = 960;
  localparam int unsigned AttrBytes     = 64;
  localparam logic [15:0] CartLimit     = 16'h2000;
  localparam logic [15:0] PalBase       = 16'h3F00;
  localparam logic [15:0] IoBase        = 16'h4000;
  localparam logic [15:0] AttrOffset    = 16'h03C0;
  localparam int unsigned ResultLatency = 2;
  localparam int unsigned LongHold      = 64;
  localparam int unsigned NumDirected   = 24;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 100;
  localparam int unsigned MaxShown      = 10;

  typedef enum logic [1:0] {
    SlotNone,
    SlotName,
    SlotAttr,
    SlotPal
  } slot_kind_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       cart;
    logic [7:0] bg_colour;
  } bus_result_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        typed;
    bus_result_t res;
  } bus_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [15:0] address, [23:16] write_data
  logic [0:0]  s_axis_tuser;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] read_data, [15:8] background_colour
  logic [0:0]  m_axis_tuser;   // [0] cartridge_access
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i;
  logic [1:0]  cfg_data_i;

  video_bus_nametable_palette_map #(.NUM_TABLES(NumTables)) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_addr_i,
    .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the block state
  logic [1:0] mirror_sel [4];
  logic [7:0] name_mem [NumTables*NameBytes];
  logic [7:0] attr_mem [NumTables*AttrBytes];
  logic [7:0] pal_mem  [32];
  bit         name_ok  [NumTables*NameBytes];
  bit         attr_ok  [NumTables*AttrBytes];
  bit         pal_ok   [32];
  logic [7:0] backdrop;

  bus_result_t expected_bus_q [$];
  logic [15:0] recent_addrs [$];
  bus_row_t    directed_rows [NumDirected];

  int unsigned errors;
  int unsigned n_items, n_writes, n_reads, n_checked, n_cfg;
  int unsigned gap_pct, stall_pct;
  int unsigned hold_left;
  bit          hold_pending;

  // Locate the store byte a non-cartridge address below 0x4000 maps to.
  function automatic void locate_slot(input logic [15:0] addr, output slot_kind_e kind,
                                      output int unsigned idx);
    int unsigned tbl;
    int unsigned off;
    kind = SlotNone;
    idx  = 0;
    if (addr >= CartLimit && addr < PalBase) begin
      tbl = int'(mirror_sel[addr[11:10]]) % NumTables;
      off = addr & 16'h03FF;
      if (off < AttrOffset) begin
        kind = SlotName;
        idx  = tbl * NameBytes + off;
      end else begin
        kind = SlotAttr;
        idx  = tbl * AttrBytes + (off & 16'h003F);
      end
    end else if (addr >= PalBase && addr < IoBase) begin
      kind = SlotPal;
      idx  = addr & 16'h001F;
    end
  endfunction

  function automatic bit read_defined(input logic [15:0] addr);
    slot_kind_e  kind;
    int unsigned idx;
    locate_slot(addr, kind, idx);
    case (kind)
      SlotName: return name_ok[idx];
      SlotAttr: return attr_ok[idx];
      SlotPal:  return pal_ok[idx];
      default:  return 1'b1;
    endcase
  endfunction

  function automatic bus_result_t predict_bus_access(input logic cmd, input logic [15:0] addr,
                                                     input logic [7:0] wdata);
    bus_result_t res;
    slot_kind_e  kind;
    int unsigned idx;
    int unsigned pair;
    res.read_data = 8'h00;
    res.cart      = (addr < CartLimit);
    locate_slot(addr, kind, idx);
    case (kind)
      SlotName: begin
        if (cmd == CmdWrite) begin
          name_mem[idx] = wdata;
          name_ok[idx]  = 1'b1;
        end else begin
          res.read_data = name_mem[idx];
        end
      end
      SlotAttr: begin
        if (cmd == CmdWrite) begin
          attr_mem[idx] = wdata;
          attr_ok[idx]  = 1'b1;
        end else begin
          res.read_data = attr_mem[idx];
        end
      end
      SlotPal: begin
        if (cmd == CmdWrite) begin
          if ((addr & 16'h000F) == 16'h0000) backdrop = wdata;
          if ((addr & 16'h0003) == 16'h0000) begin
            // entry 0 of a palette lands in both halves
            pair = addr & 16'h000C;
            pal_mem[pair]           = wdata;
            pal_mem[pair | 'h10]    = wdata;
            pal_ok[pair]            = 1'b1;
            pal_ok[pair | 'h10]     = 1'b1;
          end else begin
            pal_mem[idx] = wdata;
            pal_ok[idx]  = 1'b1;
          end
        end else begin
          res.read_data = pal_mem[idx];
        end
      end
      default: ;
    endcase
    res.bg_colour = backdrop;
    return res;
  endfunction

  task automatic issue_access(input logic cmd, input logic [15:0] addr, input logic [7:0] wdata,
                              input logic typed, input bus_result_t typed_res);
    bus_result_t res;
    if (gap_pct != 0) begin
      while ($urandom_range(99) < gap_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    res = predict_bus_access(cmd, addr, wdata);
    expected_bus_q.push_back(typed ? typed_res : res);
    n_items++;
    if (cmd == CmdWrite) begin
      n_writes++;
      if (addr >= CartLimit && addr < IoBase) begin
        recent_addrs.push_back(addr);
        if (recent_addrs.size() > 64) void'(recent_addrs.pop_front());
      end
    end else begin
      n_reads++;
    end
  endtask

  task automatic random_access();
    logic        cmd;
    logic [15:0] addr;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      addr = 16'($urandom_range(16'h1FFF));
    end else if (pick < 14) begin
      addr = 16'($urandom_range(16'hFFFF, 16'h4000));
    end else if (pick < 40) begin
      addr = PalBase | 16'($urandom_range(255));
    end else begin
      addr = 16'($urandom_range(16'h3EFF, 16'h2000));
      if ($urandom_range(99) < 30) addr = addr | AttrOffset;
    end
    cmd = $urandom_range(1) ? CmdWrite : CmdRead;
    // read back something already written
    if (cmd == CmdRead && recent_addrs.size() != 0 && $urandom_range(1))
      addr = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
    if (cmd == CmdRead && !read_defined(addr)) cmd = CmdWrite;
    issue_access(cmd, addr, 8'($urandom), 1'b0, '0);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_bus_q.size() != 0);
    repeat (ResultLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_mirrors(input logic [1:0] sel [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= cfg_reg_e'(i);
      cfg_data_i  <= sel[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      mirror_sel[i] = sel[i];
      n_cfg++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: compare, then choose the next ready
  always @(posedge clk_i) begin
    bus_result_t got;
    bus_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{read_data: m_axis_tdata[7:0], cart: m_axis_tuser[0],
              bg_colour: m_axis_tdata[15:8]};
      if (expected_bus_q.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("%0t: unexpected result rd=%h cart=%b bg=%h", $time,
                   got.read_data, got.cart, got.bg_colour);
      end else begin
        want = expected_bus_q.pop_front();
        n_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= MaxShown)
            $display("%0t: mismatch rd=%h/%h cart=%b/%b bg=%h/%h (expected/actual)", $time,
                     want.read_data, got.read_data, want.cart, got.cart,
                     want.bg_colour, got.bg_colour);
        end
      end
    end
    if (hold_pending) begin
      hold_pending  <= 1'b0;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic [1:0] sel [4];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CfgMirror0;
    cfg_data_i    = '0;
    hold_pending  = 1'b0;
    hold_left     = 0;
    gap_pct       = 0;
    stall_pct     = 0;
    errors        = 0;
    n_items = 0; n_writes = 0; n_reads = 0; n_checked = 0; n_cfg = 0;
    mirror_sel = '{MirrorRst0, MirrorRst1, MirrorRst2, MirrorRst3};
    backdrop   = 8'h00;

    directed_rows = '{
      '{CmdRead,  16'h0000, 8'h00, 1'b1, '{8'h00, 1'b1, 8'h00}},
      '{CmdWrite, 16'h1FFF, 8'hFF, 1'b1, '{8'h00, 1'b1, 8'h00}},
      '{CmdRead,  16'h4000, 8'h00, 1'b1, '{8'h00, 1'b0, 8'h00}},
      '{CmdWrite, 16'hFFFF, 8'hAA, 1'b1, '{8'h00, 1'b0, 8'h00}},
      '{CmdRead,  16'hFFFF, 8'h55, 1'b1, '{8'h00, 1'b0, 8'h00}},
      '{CmdWrite, 16'h3F00, 8'h3F, 1'b1, '{8'h00, 1'b0, 8'h3F}},
      '{CmdRead,  16'h3F00, 8'h00, 1'b1, '{8'h3F, 1'b0, 8'h3F}},
      '{CmdRead,  16'h3F10, 8'h00, 1'b1, '{8'h3F, 1'b0, 8'h3F}},
      '{CmdWrite, 16'h3F10, 8'h21, 1'b1, '{8'h00, 1'b0, 8'h21}},
      '{CmdRead,  16'h3F00, 8'h00, 1'b1, '{8'h21, 1'b0, 8'h21}},
      '{CmdWrite, 16'h3F04, 8'h15, 1'b0, '0},
      '{CmdRead,  16'h3F14, 8'h00, 1'b0, '0},
      '{CmdWrite, 16'h3F1F, 8'h0A, 1'b0, '0},
      '{CmdRead,  16'h3FFF, 8'h00, 1'b0, '0},
      '{CmdWrite, 16'h2000, 8'h5A, 1'b0, '0},
      '{CmdRead,  16'h2800, 8'h00, 1'b0, '0},
      '{CmdWrite, 16'h27BF, 8'hC3, 1'b0, '0},
      '{CmdRead,  16'h2FBF, 8'h00, 1'b0, '0},
      '{CmdWrite, 16'h23C0, 8'h77, 1'b0, '0},
      '{CmdRead,  16'h2BC0, 8'h00, 1'b0, '0},
      '{CmdWrite, 16'h3EFF, 8'hFF, 1'b0, '0},
      '{CmdRead,  16'h36FF, 8'h00, 1'b0, '0},
      '{CmdWrite, 16'h27FF, 8'h00, 1'b0, '0},
      '{CmdRead,  16'h2FFF, 8'h00, 1'b0, '0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      issue_access(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].wdata,
                   directed_rows[i].typed, directed_rows[i].res);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      case (phase)
        0: sel = '{2'd0, 2'd0, 2'd1, 2'd1};
        1: sel = '{2'd3, 2'd3, 2'd3, 2'd3};
        2: sel = '{2'd0, 2'd1, 2'd2, 2'd3};
        3: sel = '{2'd3, 2'd2, 2'd1, 2'd0};
        4: sel = '{2'd0, 2'd0, 2'd0, 2'd0};
        default: foreach (sel[k]) sel[k] = 2'($urandom_range(3));
      endcase
      write_mirrors(sel);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 77; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 77; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        // hold the result side off while requests keep coming
        if (n == 20 && (phase == 0 || phase == 4)) hold_pending <= 1'b1;
        if (n == 50 && phase == 3) begin
          s_axis_tvalid <= 1'b0;
          do @(posedge clk_i); while (expected_bus_q.size() != 0);
        end
        random_access();
      end
    end

    drain_results();
    $display("Covered %0d requests (%0d writes, %0d reads), %0d results checked,",
             n_items, n_writes, n_reads, n_checked);
    $display("%0d selector writes across %0d mirroring setups and four idle mixes.",
             n_cfg, NumPhases + 1);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", expected_bus_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
